// ----- hw/rtl/mdw_pkg.sv -----
package mdw_pkg;

	localparam int WORD_BITS = 64;
	localparam int CNT_W     = $clog2(WORD_BITS);
	localparam int OP_DEPTH  = 4;
	localparam int RES_DEPTH = 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [7:0]           len_t;
	typedef logic [1:0]           status_t;
	typedef logic [1:0]           op_kind_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_WORD  = 1'b1;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_DIV_ZERO = 2'd1;
	localparam status_t ST_RANGE    = 2'd2;

	localparam op_kind_t OP_FINAL = 2'd0;
	localparam op_kind_t OP_LOAD  = 2'd1;
	localparam op_kind_t OP_WORD  = 2'd2;

	typedef struct packed {
		op_kind_t kind;
		word_t    data;
		len_t     index;
		logic     last;
		status_t  status;
	} op_t;

	typedef struct packed {
		word_t   quotient_word;
		len_t    word_index;
		word_t   remainder_out;
		len_t    quotient_length;
		status_t status;
		logic    is_last;
	} res_t;

endpackage

// ----- hw/rtl/multiword_divide_by_word.sv -----
// start items pass the front straight into the op queue; a word item holds the back
// for an issue step, 64 restoring steps of the shared subtractor and an emit step
// that waits while the result queue is full; the bit-serial divider takes one word at a time
// an accepted word passes the op queue, the divider and the result queue before its pop
// arst_n clears the queues, the word counter and the divider sequencer; nothing is pending
module multiword_divide_by_word #(
	parameter int MAX_WORDS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic           command,
	input  mdw_pkg::word_t divisor,
	input  mdw_pkg::len_t  length_in,
	input  mdw_pkg::word_t word_value,
	output logic           empty,
	input  logic           pop,
	output mdw_pkg::word_t quotient_word,
	output mdw_pkg::len_t  word_index,
	output mdw_pkg::word_t remainder_out,
	output mdw_pkg::len_t  quotient_length,
	output mdw_pkg::status_t status,
	output logic           is_last
);
	import mdw_pkg::*;

	logic op_push;
	logic op_full;
	logic op_pop;
	logic op_empty;
	op_t  op_in;
	op_t  op_out;
	logic res_push;
	logic res_full;
	res_t res_in;
	res_t res_out;
	logic accept;

	assign full   = op_full;
	assign accept = push && !op_full;

	mdw_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.divisor    (divisor),
		.length_in  (length_in),
		.word_value (word_value),
		.op_push    (op_push),
		.op_in      (op_in)
	);

	mdw_fifo #(
		.item_t(op_t),
		.DEPTH (OP_DEPTH)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && op_push),
		.full   (op_full),
		.din    (op_in),
		.pop    (op_pop),
		.empty  (op_empty),
		.dout   (op_out)
	);

	mdw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op_out   (op_out),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_in   (res_in)
	);

	mdw_fifo #(
		.item_t(res_t),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_out)
	);

	assign quotient_word   = res_out.quotient_word;
	assign word_index      = res_out.word_index;
	assign remainder_out   = res_out.remainder_out;
	assign quotient_length = res_out.quotient_length;
	assign status          = res_out.status;
	assign is_last         = res_out.is_last;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_op_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> !op_empty)
		else $error("back end took an op from an empty queue");

	a_start_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_START)) |-> (op_push && (op_in.kind != OP_WORD)))
		else $error("start item not queued as a start op");

endmodule

// ----- hw/rtl/mdw_fifo.sv -----
module mdw_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t din,
	input  logic  pop,
	output logic  empty,
	output item_t dout
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mdw_front.sv -----
module mdw_front #(
	parameter int MAX_WORDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          command,
	input  mdw_pkg::word_t divisor,
	input  mdw_pkg::len_t  length_in,
	input  mdw_pkg::word_t word_value,
	output logic          op_push,
	output mdw_pkg::op_t   op_in
);
	import mdw_pkg::*;

	len_t words_left_q;

	always_comb begin
		op_push      = 1'b0;
		op_in.kind   = OP_FINAL;
		op_in.data   = '0;
		op_in.index  = '0;
		op_in.last   = 1'b1;
		op_in.status = ST_OK;
		if (command == CMD_START) begin
			op_push = 1'b1;
			priority if (divisor == '0) begin
				op_in.status = ST_DIV_ZERO;
			end else if (length_in > len_t'(MAX_WORDS)) begin
				op_in.status = ST_RANGE;
			end else if (length_in == '0) begin
				op_in.status = ST_OK;
			end else begin
				op_in.kind = OP_LOAD;
				op_in.data = divisor;
				op_in.last = 1'b0;
			end
		end else begin
			// words outside an active division are dropped here
			op_push     = (words_left_q != '0);
			op_in.kind  = OP_WORD;
			op_in.data  = word_value;
			op_in.index = words_left_q - 1'b1;
			op_in.last  = (words_left_q == len_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_left_q <= '0;
		end else if (accept) begin
			if (command == CMD_START) begin
				words_left_q <= (op_in.kind == OP_LOAD) ? length_in : '0;
			end else if (words_left_q != '0) begin
				words_left_q <= words_left_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mdw_back.sv -----
module mdw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_empty,
	input  mdw_pkg::op_t   op_out,
	output logic          op_pop,
	input  logic          res_full,
	output logic          res_push,
	output mdw_pkg::res_t  res_in
);
	import mdw_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	word_t            divisor_q;
	word_t            rem_q;
	word_t            lo_q;
	word_t            quo_q;
	len_t             index_q;
	logic             last_q;
	len_t             top_q;
	len_t             top_new;
	logic             carry;
	word_t            shifted;
	logic             take;
	word_t            diff;
	logic             final_op;

	// one restoring step of remainder:word by the divisor
	assign carry   = rem_q[WORD_BITS-1];
	assign shifted = {rem_q[WORD_BITS-2:0], lo_q[WORD_BITS-1]};
	assign take    = carry || (shifted >= divisor_q);
	assign diff    = shifted - divisor_q;

	assign top_new  = ((quo_q != '0) && (top_q == '0)) ? index_q + 1'b1 : top_q;
	assign final_op = (state_q == S_IDLE) && !op_empty && (op_out.kind == OP_FINAL);

	always_comb begin
		op_pop   = (state_q == S_IDLE) && !op_empty && (!final_op || !res_full);
		res_push = !res_full && (final_op || (state_q == S_EMIT));
		if (final_op) begin
			res_in.quotient_word   = '0;
			res_in.word_index      = '0;
			res_in.remainder_out   = '0;
			res_in.quotient_length = '0;
			res_in.status          = op_out.status;
			res_in.is_last         = 1'b1;
		end else begin
			res_in.quotient_word   = quo_q;
			res_in.word_index      = index_q;
			res_in.remainder_out   = last_q ? rem_q : '0;
			res_in.quotient_length = last_q ? top_new : '0;
			res_in.status          = ST_OK;
			res_in.is_last         = last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (op_pop && (op_out.kind == OP_WORD)) begin
						state_q <= S_DIV;
						count_q <= '0;
					end
				end
				S_DIV: begin
					count_q <= count_q + 1'b1;
					if (count_q == CNT_W'(WORD_BITS - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && (op_out.kind == OP_LOAD)) begin
			divisor_q <= op_out.data;
			rem_q     <= '0;
			top_q     <= '0;
		end
		if (op_pop && (op_out.kind == OP_WORD)) begin
			lo_q    <= op_out.data;
			index_q <= op_out.index;
			last_q  <= op_out.last;
		end
		if (state_q == S_DIV) begin
			rem_q <= take ? diff : shifted;
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[WORD_BITS-2:0], take};
		end
		if ((state_q == S_EMIT) && !res_full) begin
			top_q <= top_new;
		end
	end

endmodule

// ----- dv/tb_multiword_divide_by_word.sv -----
`timescale 1ns / 100ps

module tb_multiword_divide_by_word;
	import mdw_pkg::*;

	localparam int MAX_WORDS   = 64;
	localparam int DRAIN_WAIT  = 100;
	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 950;

	typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} row_check_e;

	typedef struct {
		row_check_e chk;
		logic       cmd;
		word_t      dvsr;
		len_t       len;
		word_t      wval;
		status_t    st;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    command = CMD_START;
	word_t   divisor = '0;
	len_t    length_in = '0;
	word_t   word_value = '0;
	logic    pop = 1'b0;
	logic    full, empty, is_last;
	word_t   quotient_word, remainder_out;
	len_t    word_index, quotient_length;
	status_t status;

	multiword_divide_by_word #(.MAX_WORDS(MAX_WORDS)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .divisor(divisor), .length_in(length_in), .word_value(word_value),
		.empty(empty), .pop(pop),
		.quotient_word(quotient_word), .word_index(word_index), .remainder_out(remainder_out),
		.quotient_length(quotient_length), .status(status), .is_last(is_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// own copy of the divider state
	word_t div_reg;
	word_t part_rem;
	len_t  words_due;
	len_t  q_len_seen;
	bit    in_division;

	res_t      pending_quotients[$];
	stim_row_t dir_rows[$];
	int        errors = 0;
	int        burst_left = 0;

	function automatic bit predict_quotient(input logic cmd, input word_t d, input len_t len,
			input word_t w, output res_t r);
		logic [127:0] pair;
		logic [127:0] q_full;
		logic [127:0] r_full;
		r = '0;
		if (cmd == CMD_START) begin
			in_division = 1'b0;
			part_rem = '0;
			q_len_seen = '0;
			words_due = '0;
			if (d == '0) begin
				r.status = ST_DIV_ZERO;
				r.is_last = 1'b1;
				return 1'b1;
			end
			if (len > len_t'(MAX_WORDS)) begin
				r.status = ST_RANGE;
				r.is_last = 1'b1;
				return 1'b1;
			end
			if (len == '0) begin
				r.status = ST_OK;
				r.is_last = 1'b1;
				return 1'b1;
			end
			div_reg = d;
			words_due = len;
			in_division = 1'b1;
			return 1'b0;
		end
		if (!in_division || words_due == '0 || div_reg == '0)
			return 1'b0;
		// remainder is below the divisor, so the quotient fits in one word
		pair = {part_rem, w};
		q_full = pair / {64'd0, div_reg};
		r_full = pair % {64'd0, div_reg};
		part_rem = r_full[63:0];
		words_due = words_due - 8'd1;
		if (q_full[63:0] != '0 && q_len_seen == '0)
			q_len_seen = words_due + 8'd1;
		r.quotient_word = q_full[63:0];
		r.word_index = words_due;
		if (words_due == '0) begin
			in_division = 1'b0;
			r.remainder_out = part_rem;
			r.quotient_length = q_len_seen;
			r.is_last = 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic word_t rand_divisor();
		case ($urandom_range(0, 4))
			0: return word_t'($urandom_range(1, 1000));
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, 63);
			3: return {1'b1, 31'($urandom), $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void add_row(input row_check_e chk, input logic cmd, input word_t d,
			input len_t len, input word_t w, input status_t st);
		stim_row_t row;
		row = '{chk, cmd, d, len, w, st};
		dir_rows.push_back(row);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic hold_sender();
		@(negedge clk);
		push = 1'b0;
	endtask

	// counted is low only for a word item that the block ignores
	task automatic send_item(input logic cmd, input word_t d, input len_t len, input word_t w,
			input row_check_e chk, input status_t st, output bit counted);
		res_t pred;
		res_t typed;
		bit   has_res;
		int   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				push = 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		push = 1'b1;
		command = cmd;
		divisor = d;
		length_in = len;
		word_value = w;
		do @(posedge clk); while (full);
		has_res = predict_quotient(cmd, d, len, w, pred);
		counted = has_res || cmd == CMD_START;
		case (chk)
			CHK_PREDICT: if (has_res) pending_quotients.push_back(pred);
			CHK_TYPED: begin
				typed = '0;
				typed.status = st;
				typed.is_last = 1'b1;
				pending_quotients.push_back(typed);
			end
			default: ;
		endcase
	endtask

	// receiver stall pattern, changing character with the top two bits of rx_phase
	logic [9:0] rx_phase = '0;
	always @(negedge clk) begin
		rx_phase <= rx_phase + 10'd1;
		case (rx_phase[9:8])
			2'd0: pop = 1'b1;
			2'd1: pop = 1'($urandom_range(0, 1));
			2'd2: pop = ($urandom_range(0, 7) == 0);
			default: pop = (rx_phase[3:0] < 4'd11);
		endcase
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_quotients.size() == 0) begin
				report_mismatch($sformatf("unexpected result q=%h idx=%0d last=%b",
					quotient_word, word_index, is_last));
			end else begin
				want = pending_quotients.pop_front();
				compare_field("quotient_word", quotient_word, want.quotient_word);
				compare_field("word_index", 64'(word_index), 64'(want.word_index));
				compare_field("remainder_out", remainder_out, want.remainder_out);
				compare_field("quotient_length", 64'(quotient_length),
					64'(want.quotient_length));
				compare_field("status", 64'(status), 64'(want.status));
				compare_field("is_last", 64'(is_last), 64'(want.is_last));
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb_multiword_divide_by_word: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int    sent;
		int    n;
		int    stop_at;
		bit    counted;
		bit    paused;
		word_t d;
		len_t  len;

		div_reg = '0;
		part_rem = '0;
		words_due = '0;
		q_len_seen = '0;
		in_division = 1'b0;
		sent = 0;
		paused = 1'b0;

		// word while idle straight after reset
		add_row(CHK_NONE, CMD_WORD, '0, '0, '1, ST_OK);
		// zero divisor wins over an oversized length
		add_row(CHK_TYPED, CMD_START, '0, 8'd5, '0, ST_DIV_ZERO);
		add_row(CHK_TYPED, CMD_START, '0, 8'd255, '1, ST_DIV_ZERO);
		add_row(CHK_TYPED, CMD_START, 64'd1, 8'(MAX_WORDS + 1), '0, ST_RANGE);
		add_row(CHK_TYPED, CMD_START, '1, 8'd255, '0, ST_RANGE);
		add_row(CHK_TYPED, CMD_START, 64'd5, 8'd0, '0, ST_OK);
		add_row(CHK_NONE, CMD_WORD, 64'd7, 8'd3, 64'h1234, ST_OK);
		add_row(CHK_NONE, CMD_START, 64'd1, 8'd2, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '1, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '1, ST_OK);
		add_row(CHK_NONE, CMD_START, '1, 8'd3, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '1, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, 64'hffff_ffff_ffff_fffe, ST_OK);
		// abandoned after one word by a fresh start
		add_row(CHK_NONE, CMD_START, 64'h8000_0000_0000_0000, 8'd4, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, 64'hdead_beef_0bad_f00d, ST_OK);
		add_row(CHK_NONE, CMD_START, 64'd3, 8'd2, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, 64'h0123_4567_89ab_cdef, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '1, ST_OK);
		add_row(CHK_NONE, CMD_WORD, '1, '1, '1, ST_OK);
		// all leading quotient words zero
		add_row(CHK_NONE, CMD_START, '1, 8'd3, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, '0, ST_OK);
		add_row(CHK_PREDICT, CMD_WORD, '0, '0, 64'd5, ST_OK);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].dvsr, dir_rows[i].len, dir_rows[i].wval,
				dir_rows[i].chk, dir_rows[i].st, counted);

		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				hold_sender();
				while (pending_quotients.size() != 0) @(posedge clk);
				repeat (DRAIN_WAIT) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 2))
						0: begin d = '0; len = len_t'($urandom_range(0, 255)); end
						1: begin
							d = rand_divisor();
							len = len_t'($urandom_range(MAX_WORDS + 1, 255));
						end
						default: begin d = rand_divisor(); len = '0; end
					endcase
					send_item(CMD_START, d, len, rand_word(), CHK_PREDICT, ST_OK, counted);
					sent += counted;
				end
				1: begin
					send_item(CMD_WORD, rand_word(), len_t'($urandom_range(0, 255)),
						rand_word(), CHK_PREDICT, ST_OK, counted);
					sent += counted;
				end
				2: begin
					send_item(1'($urandom_range(0, 1)), rand_word(),
						len_t'($urandom_range(0, 255)), rand_word(), CHK_PREDICT, ST_OK,
						counted);
					sent += counted;
				end
				default: begin
					// well-formed division, now and then cut short
					n = ($urandom_range(0, 19) == 0) ? MAX_WORDS : $urandom_range(1, 6);
					stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : n;
					send_item(CMD_START, rand_divisor(), len_t'(n), rand_word(),
						CHK_PREDICT, ST_OK, counted);
					sent += counted;
					for (int k = 0; k < stop_at; k++) begin
						send_item(CMD_WORD, rand_word(), len_t'($urandom_range(0, 255)),
							rand_word(), CHK_PREDICT, ST_OK, counted);
						sent += counted;
					end
				end
			endcase
		end

		hold_sender();
		while (pending_quotients.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("tb_multiword_divide_by_word: done, clean");
		else
			$display("tb_multiword_divide_by_word: done, errors");
		$finish;
	end

endmodule

// ----- multiword_divide_by_word.f -----
hw/rtl/mdw_pkg.sv
hw/rtl/mdw_fifo.sv
hw/rtl/mdw_front.sv
hw/rtl/mdw_back.sv
hw/rtl/multiword_divide_by_word.sv
dv/tb_multiword_divide_by_word.sv
